@@ rtl/tank_level_and_heat_controller_defines.svh @@
// Assertion macros used by the tank controller sequencer (tlhc_ctrl).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TANK_LEVEL_AND_HEAT_CONTROLLER_DEFINES_SVH
`define TANK_LEVEL_AND_HEAT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TLHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TLHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlhc_pkg.sv @@
// Types and constants of the tank level and heat controller.
// Used by tlhc_ctrl, tlhc_datapath and the top level; no dependencies.
`default_nettype none
package tlhc_pkg;

  // Limits of commands
  localparam int unsigned FLOW_MAX  = 25600;
  localparam int unsigned HOT_MAX   = 2560;
  localparam int unsigned POWER_MAX = 1000000;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TEMP_TARGET  = 1'b0,
    REG_LEVEL_TARGET = 1'b1
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEL,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8,
    ST_TFIN,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_L4,
    ST_OUT
  } state_e;

  // Multiplier operand selects and accumulator operations
  typedef enum logic [2:0] {
    A_LVL, A_PROD, A_ERR, A_COLD, A_HOT, A_DTA, A_YOFF
  } a_sel_e;

  typedef enum logic [2:0] {
    B_ERR, B_KP_LVL, B_KP_OFS, B_DTI, B_KHEAT, B_DHOT, B_KLOSS, B_RECIP5
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  // Commands from sequencer to datapath
  typedef struct packed {
    logic    capture;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    fin_temp;
    logic    lv_sum;
    logic    lv_y;
    logic    lv_nt;
    logic    lv_flow;
    logic    load_out;
  } dp_cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic func;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/tank_level_and_heat_controller.sv @@
// Top level of the tank level and heat controller.
// Depends on tlhc_pkg, tlhc_ctrl and tlhc_datapath.
//
// Takes one sample word at a time: tuser 0 runs the temperature loop, tuser 1 the
// level loop, and every word returns one result word with the full command set.
// A temperature word and a level word each have their result set by the sequence
// of steps through the one shared multiplier. The next word is taken only once
// the result is in the output register, which holds it until the sink takes it,
// so a new word is not taken while the last one is still being worked on.
// Targets must be written on the cfg port only while the block is idle; the block itself does not enforce this.
`default_nettype none
module tank_level_and_heat_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [13:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tank_temp[15:0], ambient_temp[31:16], inlet_temp[47:32],
  // tank_level[61:48], outflow[76:62], zero fill
  input  wire logic [79:0] s_axis_tdata,
  // func
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // heater_power[19:0], cold_inflow[34:20], hot_inflow[46:35],
  // drain_flow[61:47], cooling[62], zero fill
  output logic      [63:0] m_axis_tdata
);

  tlhc_pkg::dp_cmd_t    cmd;
  tlhc_pkg::dp_status_t status;
  logic [62:0]          out_data;

  tlhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tlhc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (s_axis_tuser),
    .in_data_i   (s_axis_tdata[76:0]),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data};

endmodule
`default_nettype wire

@@ rtl/tlhc_datapath.sv @@
// Datapath: input and state registers, shared multiplier, accumulator, flow law.
// Depends on tlhc_pkg; driven by tlhc_ctrl.
`default_nettype none
module tlhc_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tlhc_pkg::dp_cmd_t    cmd_i,
  output tlhc_pkg::dp_status_t      status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [13:0]          cfg_wdata_i,
  input  wire logic                 func_i,
  input  wire logic [76:0]          in_data_i,
  output logic      [62:0]          out_data_o
);

  // Captured word
  logic               func_q;
  logic signed [15:0] tank_temp_q, amb_temp_q, inlet_temp_q;
  logic        [13:0] tank_level_q;
  logic        [14:0] outflow_q;
  logic        [13:0] temp_tgt_q, lvl_tgt_q;

  // Controller state
  logic        [19:0] power_q;
  logic        [14:0] cold_q, drain_q;
  logic        [11:0] hot_q;
  logic               cool_q;
  logic signed [31:0] sum_q;

  // Working registers
  logic signed [59:0] prod_q;
  logic signed [52:0] acc_q;
  logic        [28:0] y_q;
  logic signed [25:0] nt_q;
  logic        [62:0] out_q;

  assign status_o.func = func_q;

  // Capture input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q       <= func_i;
      tank_temp_q  <= in_data_i[15:0];
      amb_temp_q   <= in_data_i[31:16];
      inlet_temp_q <= in_data_i[47:32];
      tank_level_q <= in_data_i[61:48];
      outflow_q    <= in_data_i[76:62];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_tgt_q <= '0;
      lvl_tgt_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlhc_pkg::REG_TEMP_TARGET:  temp_tgt_q <= cfg_wdata_i;
        tlhc_pkg::REG_LEVEL_TARGET: lvl_tgt_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Differences used by both loops
  logic signed [16:0] err_s, dti_s, dhot_s, dta_s, t_ext;
  logic signed [14:0] eh_s;
  assign t_ext  = {tank_temp_q[15], tank_temp_q};
  assign err_s  = $signed({3'b000, temp_tgt_q}) - t_ext;
  assign dti_s  = $signed({inlet_temp_q[15], inlet_temp_q}) - t_ext;
  assign dhot_s = 17'sd20480 - t_ext;
  assign dta_s  = t_ext - $signed({amb_temp_q[15], amb_temp_q});
  assign eh_s   = $signed({1'b0, lvl_tgt_q}) - $signed({1'b0, tank_level_q});

  // Shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [63:0] mul_full;

  always_comb begin
    case (cmd_i.a_sel)
      tlhc_pkg::A_LVL:  mul_a = $signed({19'b0, tank_level_q});
      tlhc_pkg::A_PROD: mul_a = prod_q[32:0];
      tlhc_pkg::A_ERR:  mul_a = {{16{err_s[16]}}, err_s};
      tlhc_pkg::A_COLD: mul_a = $signed({18'b0, cold_q});
      tlhc_pkg::A_HOT:  mul_a = $signed({21'b0, hot_q});
      tlhc_pkg::A_DTA:  mul_a = {{16{dta_s[16]}}, dta_s};
      tlhc_pkg::A_YOFF: mul_a = $signed({4'b0, y_q});
      default:          mul_a = '0;
    endcase
    case (cmd_i.b_sel)
      tlhc_pkg::B_ERR:    mul_b = {{14{err_s[16]}}, err_s};
      tlhc_pkg::B_KP_LVL: mul_b = 31'sd1673600;
      tlhc_pkg::B_KP_OFS: mul_b = 31'sd163840;
      tlhc_pkg::B_DTI:    mul_b = {{14{dti_s[16]}}, dti_s};
      tlhc_pkg::B_KHEAT:  mul_b = 31'sd66944;
      tlhc_pkg::B_DHOT:   mul_b = {{14{dhot_s[16]}}, dhot_s};
      tlhc_pkg::B_KLOSS:  mul_b = 31'sd4096000;
      tlhc_pkg::B_RECIP5: mul_b = 31'sd858993460;
      default:            mul_b = '0;
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Product register and accumulator
  logic signed [52:0] acc_d;
  always_comb begin
    case (cmd_i.acc_op)
      tlhc_pkg::ACC_LOAD: acc_d = prod_q[52:0];
      tlhc_pkg::ACC_ADD:  acc_d = acc_q + prod_q[52:0];
      tlhc_pkg::ACC_SUB:  acc_d = acc_q - prod_q[52:0];
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[59:0];
    acc_q  <= acc_d;
  end

  // Heater power: round to watts, clamp
  logic signed [52:0] acc_rnd;
  logic        [32:0] pw_raw;
  logic        [19:0] pw_sat;
  assign acc_rnd = acc_q + 53'sd524288;
  assign pw_raw  = acc_rnd[52:20];
  always_comb begin
    if (acc_q[52] || (acc_q == '0)) pw_sat = '0;
    else if (pw_raw > 33'(tlhc_pkg::POWER_MAX)) pw_sat = 20'(tlhc_pkg::POWER_MAX);
    else pw_sat = pw_raw[19:0];
  end

  // Level integral with saturation
  logic signed [17:0] eh7;
  logic signed [33:0] sum_ext;
  logic signed [31:0] sum_sat;
  assign eh7     = $signed({eh_s, 3'b000}) - {{3{eh_s[14]}}, eh_s};
  assign sum_ext = {{2{sum_q[31]}}, sum_q} + {{16{eh7[17]}}, eh7};
  always_comb begin
    if (sum_ext > 34'sd2147483647) sum_sat = 32'sh7fffffff;
    else if (sum_ext < -34'sd2147483648) sum_sat = 32'sh80000000;
    else sum_sat = sum_ext[31:0];
  end

  // PI demand numerator, floor by 64, offset to stay positive for the /5 step
  logic signed [34:0] num_s;
  logic        [28:0] y_off;
  assign num_s = ({{20{eh_s[14]}}, eh_s} * 35'sd20000)
               + $signed({{2{sum_q[31]}}, sum_q, 1'b0}) + 35'sd160;
  assign y_off = num_s[34:6] + 29'd167772160;

  // Quotient from reciprocal product, remove offset
  logic signed [27:0] nt_full;
  assign nt_full = $signed({1'b0, prod_q[58:32]}) - 28'sd33554432;

  // Flow split
  logic signed [26:0] nt27, diff1, diff2, natu2_27;
  logic signed [18:0] natu;
  logic signed [17:0] natu2;
  logic        [14:0] ni, cold_d, drain_d;
  logic        [11:0] na, hot_d;
  logic        [14:0] out_sat;

  assign nt27  = {{1{nt_q[25]}}, nt_q};
  assign natu  = $signed({4'b0, cold_q}) + $signed({7'b0, hot_q})
               - $signed({4'b0, drain_q}) - $signed({4'b0, outflow_q});
  assign diff1 = nt27 - {{8{natu[18]}}, natu};
  assign out_sat = (outflow_q > 15'(tlhc_pkg::FLOW_MAX)) ? 15'(tlhc_pkg::FLOW_MAX) : outflow_q;

  always_comb begin
    if (diff1 < 0) ni = '0;
    else if (diff1 > 27'sd25600) ni = 15'(tlhc_pkg::FLOW_MAX);
    else ni = diff1[14:0];
  end
  assign natu2    = $signed({3'b0, ni}) + $signed({6'b0, hot_q}) - $signed({3'b0, outflow_q});
  assign natu2_27 = {{9{natu2[17]}}, natu2};
  assign diff2    = nt27 - natu2_27;

  always_comb begin
    cold_d  = '0;
    hot_d   = '0;
    drain_d = '0;
    na      = '0;
    if (!eh_s[14] && (eh_s != '0)) begin
      // filling
      cold_d = ni;
      if (!cool_q) begin
        if (natu2_27 == nt27) begin
          if (ni <= 15'(tlhc_pkg::HOT_MAX)) begin
            hot_d  = ni[11:0];
            cold_d = '0;
          end else begin
            hot_d  = 12'(tlhc_pkg::HOT_MAX);
            cold_d = ni - 15'(tlhc_pkg::HOT_MAX);
          end
        end else begin
          if (diff2 < 0) na = '0;
          else if (diff2 > 27'sd2560) na = 12'(tlhc_pkg::HOT_MAX);
          else na = diff2[11:0];
          hot_d = na;
        end
      end
    end else if (eh_s[14]) begin
      // emptying
      cold_d = out_sat;
      if (!nt27[26]) drain_d = '0;
      else if (nt27 < -27'sd25600) drain_d = 15'(tlhc_pkg::FLOW_MAX);
      else drain_d = 15'(-nt27);
    end
  end

  // Level working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lv_y)  y_q  <= y_off;
    if (cmd_i.lv_nt) nt_q <= nt_full[25:0];
  end

  // Command and integral state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      cold_q  <= '0;
      hot_q   <= '0;
      drain_q <= '0;
      cool_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (cmd_i.fin_temp) begin
        if (!err_s[16] && (err_s != '0)) begin
          power_q <= pw_sat;
          cool_q  <= 1'b0;
        end else begin
          power_q <= '0;
          cool_q  <= 1'b1;
        end
      end
      if (cmd_i.lv_sum) sum_q <= sum_sat;
      if (cmd_i.lv_flow) begin
        cold_q  <= cold_d;
        hot_q   <= hot_d;
        drain_q <= drain_d;
        if (eh_s[14]) sum_q <= '0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= {cool_q, drain_q, hot_q, cold_q, power_q};
  end
  assign out_data_o = out_q;

endmodule
`default_nettype wire

@@ rtl/tlhc_ctrl.sv @@
// Sequencer for the tank controller: handshakes and datapath command steps.
// Depends on tlhc_pkg and tank_level_and_heat_controller_defines.svh.
`default_nettype none
`include "tank_level_and_heat_controller_defines.svh"
module tlhc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire tlhc_pkg::dp_status_t  status_i,
  output tlhc_pkg::dp_cmd_t          cmd_o
);

  tlhc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlhc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tlhc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tlhc_pkg::ST_SEL;
        end
      end
      tlhc_pkg::ST_SEL: state_d = status_i.func ? tlhc_pkg::ST_L0 : tlhc_pkg::ST_T0;
      // temperature: level-scaled gain term
      tlhc_pkg::ST_T0: begin
        cmd_o.a_sel = tlhc_pkg::A_LVL;  cmd_o.b_sel = tlhc_pkg::B_ERR;
        state_d = tlhc_pkg::ST_T1;
      end
      tlhc_pkg::ST_T1: begin
        cmd_o.a_sel = tlhc_pkg::A_PROD; cmd_o.b_sel = tlhc_pkg::B_KP_LVL;
        state_d = tlhc_pkg::ST_T2;
      end
      tlhc_pkg::ST_T2: begin
        cmd_o.a_sel = tlhc_pkg::A_ERR;  cmd_o.b_sel = tlhc_pkg::B_KP_OFS;
        cmd_o.acc_op = tlhc_pkg::ACC_LOAD;
        state_d = tlhc_pkg::ST_T3;
      end
      // cold inflow heat
      tlhc_pkg::ST_T3: begin
        cmd_o.a_sel = tlhc_pkg::A_COLD; cmd_o.b_sel = tlhc_pkg::B_DTI;
        cmd_o.acc_op = tlhc_pkg::ACC_ADD;
        state_d = tlhc_pkg::ST_T4;
      end
      tlhc_pkg::ST_T4: begin
        cmd_o.a_sel = tlhc_pkg::A_PROD; cmd_o.b_sel = tlhc_pkg::B_KHEAT;
        state_d = tlhc_pkg::ST_T5;
      end
      // hot inflow heat
      tlhc_pkg::ST_T5: begin
        cmd_o.a_sel = tlhc_pkg::A_HOT;  cmd_o.b_sel = tlhc_pkg::B_DHOT;
        cmd_o.acc_op = tlhc_pkg::ACC_SUB;
        state_d = tlhc_pkg::ST_T6;
      end
      tlhc_pkg::ST_T6: begin
        cmd_o.a_sel = tlhc_pkg::A_PROD; cmd_o.b_sel = tlhc_pkg::B_KHEAT;
        state_d = tlhc_pkg::ST_T7;
      end
      // losses to ambient
      tlhc_pkg::ST_T7: begin
        cmd_o.a_sel = tlhc_pkg::A_DTA;  cmd_o.b_sel = tlhc_pkg::B_KLOSS;
        cmd_o.acc_op = tlhc_pkg::ACC_SUB;
        state_d = tlhc_pkg::ST_T8;
      end
      tlhc_pkg::ST_T8: begin
        cmd_o.acc_op = tlhc_pkg::ACC_ADD;
        state_d = tlhc_pkg::ST_TFIN;
      end
      tlhc_pkg::ST_TFIN: begin
        cmd_o.fin_temp = 1'b1;
        state_d = tlhc_pkg::ST_OUT;
      end
      // level: integral, numerator, divide by five, flow split
      tlhc_pkg::ST_L0: begin
        cmd_o.lv_sum = 1'b1;
        state_d = tlhc_pkg::ST_L1;
      end
      tlhc_pkg::ST_L1: begin
        cmd_o.lv_y = 1'b1;
        state_d = tlhc_pkg::ST_L2;
      end
      tlhc_pkg::ST_L2: begin
        cmd_o.a_sel = tlhc_pkg::A_YOFF; cmd_o.b_sel = tlhc_pkg::B_RECIP5;
        state_d = tlhc_pkg::ST_L3;
      end
      tlhc_pkg::ST_L3: begin
        cmd_o.lv_nt = 1'b1;
        state_d = tlhc_pkg::ST_L4;
      end
      tlhc_pkg::ST_L4: begin
        cmd_o.lv_flow = 1'b1;
        state_d = tlhc_pkg::ST_OUT;
      end
      // hand the word to the output register once it is free
      tlhc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tlhc_pkg::ST_IDLE;
        end
      end
      default: state_d = tlhc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `TLHC_ASSERT_IMP(a_load_into_free_slot, cmd_o.load_out, !out_valid_q || out_ready_i, "result word overwritten")
  `TLHC_ASSERT_NXT(a_accept_starts_work, in_valid_i && in_ready_o, state_q == tlhc_pkg::ST_SEL, "accept did not start work")
  `TLHC_ASSERT_IMP(a_one_update, 1'b1, $onehot0({cmd_o.capture, cmd_o.fin_temp, cmd_o.lv_sum, cmd_o.lv_y, cmd_o.lv_nt, cmd_o.lv_flow, cmd_o.load_out}), "overlapping datapath updates")

endmodule
`default_nettype wire
